/* src/range_toggle_min_max_tracker_macros.svh */
// Assertion macros for the range toggle min/max tracker.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef RANGE_TOGGLE_MIN_MAX_TRACKER_MACROS_SVH
`define RANGE_TOGGLE_MIN_MAX_TRACKER_MACROS_SVH

// Property checked only while out of reset.
`define RTMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define RTMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/rtmm_pkg.sv */
// Shared types and constants for the range toggle min/max tracker.
// No dependencies; used by rtmm_cell and the top level.
`timescale 1ns / 1ps

package rtmm_pkg;

  localparam int OP_W     = 2;
  localparam int LO_W     = 8;
  localparam int HI_W     = 9;
  localparam int KEY_IN_W = 16;
  localparam int KEY_OUT_W = 16;
  localparam int IDX_OUT_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ON    = 2'd1,
    OP_OFF   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // One transaction as it travels down the row of cells.
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [LO_W-1:0]     lo;
    logic [HI_W-1:0]     hi;
    logic [KEY_IN_W-1:0] key;
  } cmd_t;

endpackage

/* src/rtmm_cell.sv */
// One table entry of the tracker: active flag, key, and one pipeline stage
// of the traveling transaction and query accumulator. Depends on rtmm_pkg.
`timescale 1ns / 1ps

module rtmm_cell #(
  parameter int ENTRIES   = 256,
  parameter int KEY_WIDTH = 16,
  parameter int IDX       = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  rtmm_pkg::cmd_t               cmd_i,
  input  logic                         any_i,
  input  logic [KEY_WIDTH-1:0]         min_key_i,
  input  logic [$clog2(ENTRIES)-1:0]   min_idx_i,
  input  logic [KEY_WIDTH-1:0]         max_key_i,
  input  logic [$clog2(ENTRIES)-1:0]   max_idx_i,
  output rtmm_pkg::cmd_t               cmd_o,
  output logic                         any_o,
  output logic [KEY_WIDTH-1:0]         min_key_o,
  output logic [$clog2(ENTRIES)-1:0]   min_idx_o,
  output logic [KEY_WIDTH-1:0]         max_key_o,
  output logic [$clog2(ENTRIES)-1:0]   max_idx_o
);
  import rtmm_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CMP_W = (IDX_W + 1 > HI_W) ? IDX_W + 1 : HI_W;
  localparam logic [CMP_W-1:0] MY_CMP = CMP_W'(IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                 valid_r;
  cmd_t                 cmd_r;
  logic                 active_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 any_r,     any_nxt;
  logic [KEY_WIDTH-1:0] min_key_r, min_key_nxt;
  logic [IDX_W-1:0]     min_idx_r, min_idx_nxt;
  logic [KEY_WIDTH-1:0] max_key_r, max_key_nxt;
  logic [IDX_W-1:0]     max_idx_r, max_idx_nxt;
  logic                 hit_range;
  logic                 hit_load;

  assign hit_range = (CMP_W'(cmd_i.lo) <= MY_CMP) && (MY_CMP < CMP_W'(cmd_i.hi));
  assign hit_load  = (CMP_W'(cmd_i.lo) == MY_CMP);

  // Fold this entry into the running min/max; strict compares keep the
  // lower index on ties since lower indices pass first.
  always_comb begin
    any_nxt     = any_i;
    min_key_nxt = min_key_i;
    min_idx_nxt = min_idx_i;
    max_key_nxt = max_key_i;
    max_idx_nxt = max_idx_i;
    if (cmd_i.op == OP_QUERY && active_r) begin
      if (!any_i) begin
        any_nxt     = 1'b1;
        min_key_nxt = key_r;
        min_idx_nxt = MY_IDX;
        max_key_nxt = key_r;
        max_idx_nxt = MY_IDX;
      end else begin
        if (key_r < min_key_i) begin
          min_key_nxt = key_r;
          min_idx_nxt = MY_IDX;
        end
        if (key_r > max_key_i) begin
          max_key_nxt = key_r;
          max_idx_nxt = MY_IDX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
    end else if (advance) begin
      valid_r <= cmd_i.valid;
      if (cmd_i.valid) begin
        case (cmd_i.op)
          OP_ON:   if (hit_range) active_r <= 1'b1;
          OP_OFF:  if (hit_range) active_r <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_r     <= cmd_i;
      any_r     <= any_nxt;
      min_key_r <= min_key_nxt;
      min_idx_r <= min_idx_nxt;
      max_key_r <= max_key_nxt;
      max_idx_r <= max_idx_nxt;
      if (cmd_i.valid && cmd_i.op == OP_LOAD && hit_load) begin
        key_r <= KEY_WIDTH'(cmd_i.key);
      end
    end
  end

  always_comb begin
    cmd_o       = cmd_r;
    cmd_o.valid = valid_r;
  end

  assign any_o     = any_r;
  assign min_key_o = min_key_r;
  assign min_idx_o = min_idx_r;
  assign max_key_o = max_key_r;
  assign max_idx_o = max_idx_r;

endmodule

/* src/range_toggle_min_max_tracker.sv */
// Top level of the range toggle min/max tracker: a row of rtmm_cell stages
// and the result register. Depends on rtmm_pkg and rtmm_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   load a key, switch an index range on, switch it off, or query. Only a
//   query produces a result on the output channel (out_valid/out_ready).
//   Every transaction walks the row of ENTRIES cells, one cell per cycle
//   while the row advances; each cell applies it to its own entry as it
//   passes, so transactions are applied in arrival order.
//   Throughput: one transaction per cycle while the row is not held, set by
//   the one-cell-per-cycle step of the row. A query's result passes the
//   ENTRIES cell stages and then the result register before it is shown.
//   Reset clears every active flag and all in-flight transactions; keys are
//   not cleared and must be loaded before their entries are switched on.
//   When a result waits and out_ready is low, the whole row holds and
//   in_ready drops until the result is taken.
`timescale 1ns / 1ps

module range_toggle_min_max_tracker #(
  parameter int ENTRIES   = 256,
  parameter int KEY_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rtmm_pkg::OP_W-1:0]         in_operation,
  input  logic [rtmm_pkg::LO_W-1:0]         in_index_low,
  input  logic [rtmm_pkg::HI_W-1:0]         in_index_high,
  input  logic [rtmm_pkg::KEY_IN_W-1:0]     in_key_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_any_active,
  output logic [rtmm_pkg::KEY_OUT_W-1:0]    out_min_key,
  output logic [rtmm_pkg::IDX_OUT_W-1:0]    out_min_index,
  output logic [rtmm_pkg::KEY_OUT_W-1:0]    out_max_key,
  output logic [rtmm_pkg::IDX_OUT_W-1:0]    out_max_index
);
  import rtmm_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  cmd_t                 cmd_w     [0:ENTRIES];
  logic                 any_w     [0:ENTRIES];
  logic [KEY_WIDTH-1:0] min_key_w [0:ENTRIES];
  logic [IDX_W-1:0]     min_idx_w [0:ENTRIES];
  logic [KEY_WIDTH-1:0] max_key_w [0:ENTRIES];
  logic [IDX_W-1:0]     max_idx_w [0:ENTRIES];

  logic                 advance;
  logic                 out_valid_r;
  logic                 any_r;
  logic [KEY_OUT_W-1:0] min_key_r;
  logic [IDX_OUT_W-1:0] min_idx_r;
  logic [KEY_OUT_W-1:0] max_key_r;
  logic [IDX_OUT_W-1:0] max_idx_r;

  // Hold the row while a result waits and the receiver stalls.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  always_comb begin
    cmd_w[0].valid = in_valid;
    cmd_w[0].op    = op_t'(in_operation);
    cmd_w[0].lo    = in_index_low;
    cmd_w[0].hi    = in_index_high;
    cmd_w[0].key   = in_key_value;
  end

  assign any_w[0]     = 1'b0;
  assign min_key_w[0] = '0;
  assign min_idx_w[0] = '0;
  assign max_key_w[0] = '0;
  assign max_idx_w[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rtmm_cell #(
      .ENTRIES   (ENTRIES),
      .KEY_WIDTH (KEY_WIDTH),
      .IDX       (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .cmd_i     (cmd_w[g]),
      .any_i     (any_w[g]),
      .min_key_i (min_key_w[g]),
      .min_idx_i (min_idx_w[g]),
      .max_key_i (max_key_w[g]),
      .max_idx_i (max_idx_w[g]),
      .cmd_o     (cmd_w[g+1]),
      .any_o     (any_w[g+1]),
      .min_key_o (min_key_w[g+1]),
      .min_idx_o (min_idx_w[g+1]),
      .max_key_o (max_key_w[g+1]),
      .max_idx_o (max_idx_w[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= cmd_w[ENTRIES].valid && cmd_w[ENTRIES].op == OP_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      any_r     <= any_w[ENTRIES];
      min_key_r <= KEY_OUT_W'(min_key_w[ENTRIES]);
      min_idx_r <= IDX_OUT_W'(min_idx_w[ENTRIES]);
      max_key_r <= KEY_OUT_W'(max_key_w[ENTRIES]);
      max_idx_r <= IDX_OUT_W'(max_idx_w[ENTRIES]);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_any_active = any_r;
  assign out_min_key    = min_key_r;
  assign out_min_index  = min_idx_r;
  assign out_max_key    = max_key_r;
  assign out_max_index  = max_idx_r;

endmodule

/* src/rtmm_checker.sv */
// Port-level checker for the range toggle min/max tracker, bound to the top.
// Depends on range_toggle_min_max_tracker_macros.svh.
`timescale 1ns / 1ps
`include "range_toggle_min_max_tracker_macros.svh"

module rtmm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_any_active,
  input logic [15:0] out_min_key,
  input logic [7:0]  out_min_index,
  input logic [15:0] out_max_key,
  input logic [7:0]  out_max_index
);

  `RTMM_ASSERT_ALWAYS(a_no_result_after_reset, !rst_n |=> !out_valid, "result valid after reset")

  `RTMM_ASSERT(a_ready_when_free, !out_valid |-> in_ready, "input stalled with free output")

  `RTMM_ASSERT(a_empty_is_zero, out_valid && !out_any_active |-> out_min_key == 16'd0 && out_max_key == 16'd0 && out_min_index == 8'd0 && out_max_index == 8'd0, "nonzero fields with nothing active")

  `RTMM_ASSERT(a_min_le_max, out_valid && out_any_active |-> out_min_key <= out_max_key, "min key above max key")

  `RTMM_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_min_key) && $stable(out_max_key), "stalled result changed")

endmodule

bind range_toggle_min_max_tracker rtmm_checker u_rtmm_checker (.*);
